>>> src/ppmp6_pkg.sv
// ----------------------------------------------------------------------------
// ppmp6_pkg
// shared types and constants of the binary ppm stream parser
// ----------------------------------------------------------------------------
package ppmp6_pkg;

  // default token length bound and front/back queue depth
  localparam int MAX_TOKEN_LEN = 32;
  localparam int QUEUE_DEPTH   = 2;

  // final status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_CORRUPT     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_P     = 8'h50;

  // header numbers
  localparam logic [32:0] VALUE_SAT   = 33'h1_0000_0000;
  localparam logic [32:0] MAXVAL_REQ  = 33'd255;
  // largest pixel count whose byte count fits in 64 bits
  localparam logic [63:0] PIXEL_LIMIT = 64'h5555_5555_5555_5555;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [1:0]  parse_status;
    logic        final_item;
  } out_beat_t;

  // classified byte, front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       is_ws;
    logic       is_eol;
    logic       is_hash;
    logic       is_digit;
    logic       is_plus;
    logic       is_p;
    logic       is_six;
  } class_rec_t;

endpackage

>>> src/ppmp6_front.sv
// ----------------------------------------------------------------------------
// ppmp6_front
// takes input beats and tags each byte with its character class
// ----------------------------------------------------------------------------
module ppmp6_front (
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  ppmp6_pkg::in_beat_t   byte_data,
  input  logic                  q_full,
  output logic                  q_push,
  output ppmp6_pkg::class_rec_t q_rec
);

  logic [7:0] b;

  assign b          = byte_data.data_byte;
  assign byte_ready = !q_full;
  assign q_push     = byte_valid && !q_full;

  always_comb begin
    q_rec.data_byte   = b;
    q_rec.end_of_file = byte_data.end_of_file;
    q_rec.is_ws       = (b == ppmp6_pkg::CH_SPACE) || (b == ppmp6_pkg::CH_TAB) ||
                        (b == ppmp6_pkg::CH_LF) || (b == ppmp6_pkg::CH_CR) ||
                        (b == ppmp6_pkg::CH_FF) || (b == ppmp6_pkg::CH_VT);
    q_rec.is_eol      = (b == ppmp6_pkg::CH_LF) || (b == ppmp6_pkg::CH_CR);
    q_rec.is_hash     = (b == ppmp6_pkg::CH_HASH);
    q_rec.is_digit    = (b >= ppmp6_pkg::CH_ZERO) && (b <= ppmp6_pkg::CH_NINE);
    q_rec.is_plus     = (b == ppmp6_pkg::CH_PLUS);
    q_rec.is_p        = (b == ppmp6_pkg::CH_P);
    q_rec.is_six      = (b == ppmp6_pkg::CH_SIX);
  end

endmodule

>>> src/ppmp6_queue.sv
// ----------------------------------------------------------------------------
// ppmp6_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module ppmp6_queue #(
  parameter int DEPTH = ppmp6_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ppmp6_pkg::class_rec_t push_rec,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output ppmp6_pkg::class_rec_t rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ppmp6_pkg::class_rec_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign valid = (count != '0);
  assign rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

>>> src/ppmp6_back.sv
// ----------------------------------------------------------------------------
// ppmp6_back
// header parser, raster walker and result register with one spare slot
// ----------------------------------------------------------------------------
module ppmp6_back #(
  parameter int MAX_TOKEN_LEN = ppmp6_pkg::MAX_TOKEN_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ppmp6_pkg::class_rec_t q_rec,
  output logic                  q_pop,
  output logic                  result_valid,
  input  logic                  result_ready,
  output ppmp6_pkg::out_beat_t  result_data
);

  localparam int TLEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [TLEN_W-1:0] TLEN_MAX = TLEN_W'(MAX_TOKEN_LEN);
  localparam logic [TLEN_W-1:0] TLEN_ONE = TLEN_W'(1);
  localparam logic [TLEN_W-1:0] TLEN_TWO = TLEN_W'(2);

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_RASTER = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  localparam logic [1:0] END_WS   = 2'd0;
  localparam logic [1:0] END_HASH = 2'd1;
  localparam logic [1:0] END_EOF  = 2'd2;

  logic [2:0]        phase, phase_next;
  logic              in_comment, in_comment_next;
  logic [TLEN_W-1:0] tok_len, tok_len_next;
  logic [32:0]       tok_val, tok_val_next;
  logic              tok_bad, tok_bad_next;
  logic [1:0]        magic_match, magic_match_next;
  logic              digit_seen, digit_seen_next;
  logic [31:0]       width_reg, width_reg_next;
  logic [31:0]       height_reg, height_reg_next;
  logic [1:0]        first_error, first_error_next;
  logic [63:0]       pix_rem, pix_rem_next;
  logic [1:0]        chan, chan_next;
  logic [7:0]        held_red, held_red_next;
  logic [7:0]        held_green, held_green_next;
  logic [63:0]       pixels;

  logic                 emit_pix, emit_stat;
  ppmp6_pkg::out_beat_t pix_item, stat_item;
  logic                 spare_valid;
  ppmp6_pkg::out_beat_t spare_item;
  logic                 room;

  assign room  = !result_valid || result_ready;
  assign q_pop = q_valid && room && !spare_valid;

  // pixel count, ready by the time maxval closes
  always_ff @(posedge clk) begin
    pixels <= 64'(width_reg) * 64'(height_reg);
  end

  always_comb begin
    logic              add;
    logic              do_close;
    logic [1:0]        how;
    logic [TLEN_W-1:0] a_len;
    logic [32:0]       a_val;
    logic              a_bad;
    logic [1:0]        a_mm;
    logic              a_dig;
    logic [35:0]       prod;
    logic              num_ok;

    phase_next       = phase;
    in_comment_next  = in_comment;
    tok_len_next     = tok_len;
    tok_val_next     = tok_val;
    tok_bad_next     = tok_bad;
    magic_match_next = magic_match;
    digit_seen_next  = digit_seen;
    width_reg_next   = width_reg;
    height_reg_next  = height_reg;
    first_error_next = first_error;
    pix_rem_next     = pix_rem;
    chan_next        = chan;
    held_red_next    = held_red;
    held_green_next  = held_green;
    emit_pix         = 1'b0;
    emit_stat        = 1'b0;

    add      = 1'b0;
    do_close = 1'b0;
    how      = END_WS;
    a_len    = tok_len;
    a_val    = tok_val;
    a_bad    = tok_bad;
    a_mm     = magic_match;
    a_dig    = digit_seen;
    prod     = '0;
    num_ok   = 1'b0;

    pix_item.result_kind  = 1'b0;
    pix_item.red          = held_red;
    pix_item.green        = held_green;
    pix_item.blue         = q_rec.data_byte;
    pix_item.image_width  = '0;
    pix_item.image_height = '0;
    pix_item.parse_status = ppmp6_pkg::ST_OK;
    pix_item.final_item   = 1'b0;

    stat_item.result_kind  = 1'b1;
    stat_item.red          = '0;
    stat_item.green        = '0;
    stat_item.blue         = '0;
    stat_item.image_width  = '0;
    stat_item.image_height = '0;
    stat_item.parse_status = ppmp6_pkg::ST_OK;
    stat_item.final_item   = 1'b1;

    if (q_pop) begin
      if (phase inside {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL}) begin
        if (in_comment) begin
          if (q_rec.is_eol) begin
            in_comment_next = 1'b0;
          end
        end else if (tok_len == '0) begin
          if (q_rec.is_hash) begin
            in_comment_next = 1'b1;
          end else if (!q_rec.is_ws) begin
            add = 1'b1;
          end
        end else if (q_rec.is_ws) begin
          do_close = 1'b1;
          how      = END_WS;
        end else if (q_rec.is_hash) begin
          do_close = 1'b1;
          how      = END_HASH;
        end else begin
          add = 1'b1;
        end
        // a token still open at end of file closes after this byte
        if (q_rec.end_of_file && add) begin
          do_close = 1'b1;
          how      = END_EOF;
        end

        if (add) begin
          if (phase == PH_MAGIC) begin
            if (tok_len == '0 && q_rec.is_p) begin
              a_mm = 2'd1;
            end else if (tok_len == TLEN_ONE && q_rec.is_six && magic_match == 2'd1) begin
              a_mm = 2'd2;
            end else begin
              a_bad = 1'b1;
            end
          end else if (q_rec.is_digit) begin
            if (!tok_val[32]) begin
              prod  = {1'b0, tok_val[31:0], 3'b000} + {3'b000, tok_val[31:0], 1'b0} +
                      {32'd0, q_rec.data_byte[3:0]};
              a_val = (prod[35:32] != 4'd0) ? ppmp6_pkg::VALUE_SAT : {1'b0, prod[31:0]};
            end
            a_dig = 1'b1;
          end else if (!(q_rec.is_plus && tok_len == '0)) begin
            a_bad = 1'b1;
          end
          if (tok_len < TLEN_MAX) begin
            a_len = tok_len + 1'b1;
          end
        end
        tok_len_next     = a_len;
        tok_val_next     = a_val;
        tok_bad_next     = a_bad;
        magic_match_next = a_mm;
        digit_seen_next  = a_dig;

        if (do_close) begin
          num_ok = (a_len < TLEN_MAX) && !a_bad && a_dig && !a_val[32];
          case (phase)
            PH_MAGIC: begin
              if (a_len == TLEN_MAX) begin
                first_error_next = ppmp6_pkg::ST_CORRUPT;
                phase_next       = PH_HALT;
              end else if (a_bad || a_len != TLEN_TWO || a_mm != 2'd2) begin
                first_error_next = ppmp6_pkg::ST_UNSUPPORTED;
                phase_next       = PH_HALT;
              end else begin
                phase_next = PH_WIDTH;
              end
            end
            PH_WIDTH: begin
              if (!num_ok) begin
                first_error_next = ppmp6_pkg::ST_CORRUPT;
                phase_next       = PH_HALT;
              end else begin
                width_reg_next = a_val[31:0];
                phase_next     = PH_HEIGHT;
              end
            end
            PH_HEIGHT: begin
              if (!num_ok) begin
                first_error_next = ppmp6_pkg::ST_CORRUPT;
                phase_next       = PH_HALT;
              end else begin
                height_reg_next = a_val[31:0];
                phase_next      = PH_MAXVAL;
              end
            end
            PH_MAXVAL: begin
              if (!num_ok || width_reg == '0 || height_reg == '0) begin
                first_error_next = ppmp6_pkg::ST_CORRUPT;
                phase_next       = PH_HALT;
              end else if (a_val != ppmp6_pkg::MAXVAL_REQ) begin
                first_error_next = ppmp6_pkg::ST_UNSUPPORTED;
                phase_next       = PH_HALT;
              end else if (how != END_WS || pixels > ppmp6_pkg::PIXEL_LIMIT) begin
                first_error_next = ppmp6_pkg::ST_CORRUPT;
                phase_next       = PH_HALT;
              end else begin
                pix_rem_next = pixels;
                chan_next    = 2'd0;
                phase_next   = PH_RASTER;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
          tok_len_next     = '0;
          tok_val_next     = '0;
          tok_bad_next     = 1'b0;
          magic_match_next = 2'd0;
          digit_seen_next  = 1'b0;
          if (how == END_HASH &&
              phase_next inside {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL}) begin
            in_comment_next = 1'b1;
          end
        end
      end else if (phase == PH_RASTER) begin
        case (chan)
          2'd0: begin
            held_red_next = q_rec.data_byte;
            chan_next     = 2'd1;
          end
          2'd1: begin
            held_green_next = q_rec.data_byte;
            chan_next       = 2'd2;
          end
          default: begin
            emit_pix     = 1'b1;
            chan_next    = 2'd0;
            pix_rem_next = pix_rem - 64'd1;
            if (pix_rem == 64'd1) begin
              phase_next = PH_TRAIL;
            end
          end
        endcase
      end else if (phase == PH_TRAIL) begin
        if (!q_rec.is_ws) begin
          first_error_next = ppmp6_pkg::ST_CORRUPT;
          phase_next       = PH_HALT;
        end
      end

      if (q_rec.end_of_file) begin
        if (phase_next inside {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_RASTER}) begin
          if (first_error_next == ppmp6_pkg::ST_OK) begin
            first_error_next = ppmp6_pkg::ST_CORRUPT;
          end
        end
        emit_stat              = 1'b1;
        stat_item.parse_status = first_error_next;
        if (first_error_next == ppmp6_pkg::ST_OK) begin
          stat_item.image_width  = width_reg;
          stat_item.image_height = height_reg;
        end
        // back to the reset state for the next file
        phase_next       = PH_MAGIC;
        in_comment_next  = 1'b0;
        tok_len_next     = '0;
        tok_val_next     = '0;
        tok_bad_next     = 1'b0;
        magic_match_next = 2'd0;
        digit_seen_next  = 1'b0;
        width_reg_next   = '0;
        height_reg_next  = '0;
        first_error_next = ppmp6_pkg::ST_OK;
        pix_rem_next     = '0;
        chan_next        = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      in_comment  <= 1'b0;
      tok_len     <= '0;
      tok_val     <= '0;
      tok_bad     <= 1'b0;
      magic_match <= 2'd0;
      digit_seen  <= 1'b0;
      width_reg   <= '0;
      height_reg  <= '0;
      first_error <= ppmp6_pkg::ST_OK;
      pix_rem     <= '0;
      chan        <= 2'd0;
    end else begin
      phase       <= phase_next;
      in_comment  <= in_comment_next;
      tok_len     <= tok_len_next;
      tok_val     <= tok_val_next;
      tok_bad     <= tok_bad_next;
      magic_match <= magic_match_next;
      digit_seen  <= digit_seen_next;
      width_reg   <= width_reg_next;
      height_reg  <= height_reg_next;
      first_error <= first_error_next;
      pix_rem     <= pix_rem_next;
      chan        <= chan_next;
    end
  end

  always_ff @(posedge clk) begin
    held_red   <= held_red_next;
    held_green <= held_green_next;
  end

  // result register plus spare slot for the status after a last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else if (room) begin
      if (spare_valid) begin
        result_valid <= 1'b1;
        spare_valid  <= 1'b0;
      end else if (emit_pix || emit_stat) begin
        result_valid <= 1'b1;
        spare_valid  <= emit_pix && emit_stat;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      if (spare_valid) begin
        result_data <= spare_item;
      end else if (emit_pix) begin
        result_data <= pix_item;
      end else if (emit_stat) begin
        result_data <= stat_item;
      end
    end
    if (q_pop && emit_pix && emit_stat) begin
      spare_item <= stat_item;
    end
  end

endmodule

>>> src/ppm_p6_stream_parser_top.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_top
// binary ppm (p6) stream parser: header check, pixel output, final status
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                    beat
//   byte      in          byte_valid / byte_ready      one file byte, eof flag
//   result    out         result_valid / result_ready  one pixel or status item
//
// one byte is taken per cycle while the result side keeps up; the parser in
// the back end retires one queued byte per cycle while the result register
// has room and the spare slot is empty, and registers a result as its byte
// leaves the queue; an end-of-file byte closing a pixel gives two beats, so
// the back end holds the queue while the status beat waits in the spare slot
// a two-beat queue between the classifier and the parser absorbs result
// stalls; input ready drops only when that queue is full
// reset is synchronous; no clearing pass, the block takes bytes right after
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser_top #(
  parameter int MAX_TOKEN_LEN = ppmp6_pkg::MAX_TOKEN_LEN,
  parameter int QUEUE_DEPTH   = ppmp6_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  ppmp6_pkg::in_beat_t  byte_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ppmp6_pkg::out_beat_t result_data
);

  // classified byte into the queue
  logic                  q_push;
  ppmp6_pkg::class_rec_t push_rec;
  logic                  q_full;

  // queue head toward the parser
  logic                  q_valid;
  logic                  q_pop;
  ppmp6_pkg::class_rec_t head_rec;

  // front: handshake and character classes
  ppmp6_front u_front (
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (push_rec)
  );

  // decoupling queue, lets either side stall alone
  ppmp6_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .rec      (head_rec)
  );

  // back: header tokens, size product, raster walk, sticky first error
  ppmp6_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (head_rec),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// byte-stream checks of the binary ppm (p6) parser: header syntax, pixel
// beats and the final status beat; a parser kept in step with the block
// predicts every result beat, and random gaps on both sides stress the
// handshakes
// ----------------------------------------------------------------------------
module tb_top;

  // phases of the header walk, raster and tail
  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_RASTER, PH_TRAIL, PH_HALT
  } parse_phase_e;

  // what ended a header token
  typedef enum logic [1:0] {END_WS, END_HASH, END_EOF} token_end_e;

  localparam logic [63:0] VALUE_MAX   = 64'hFFFF_FFFF;
  // largest pixel count whose byte count still fits in 64 bits
  localparam logic [63:0] MAX_PIXELS  = 64'hFFFF_FFFF_FFFF_FFFF / 3;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_BYTES = 220;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  ppmp6_pkg::in_beat_t  byte_data = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  ppmp6_pkg::out_beat_t result_data;

  // calm: no new gaps on either side while set
  bit        calm = 1'b0;
  int        hold_cycles = 0;
  int        cycle_count = 0;
  int        bad_beats = 0;

  // file under construction, sent whole with eof on its last byte
  logic [7:0] file_buf[$];
  // result beats the parser copy says are still to come
  ppmp6_pkg::out_beat_t ppm_beats_due[$];

  // parser copy state
  parse_phase_e hdr_phase;
  bit           in_cmt;
  int           tok_len;
  logic [63:0]  tok_val;
  bit           tok_bad;
  int           magic_hits;
  bit           got_digit;
  logic [31:0]  img_w;
  logic [31:0]  img_h;
  logic [1:0]   err_code;
  logic [63:0]  bytes_left;
  int           chan;
  logic [7:0]   red_hold;
  logic [7:0]   green_hold;

  ppm_p6_stream_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parser copy

  function automatic bit is_space(logic [7:0] b);
    return b == ppmp6_pkg::CH_SPACE || b == ppmp6_pkg::CH_TAB ||
           b == ppmp6_pkg::CH_LF || b == ppmp6_pkg::CH_CR ||
           b == ppmp6_pkg::CH_FF || b == ppmp6_pkg::CH_VT;
  endfunction

  function automatic void restart_token();
    tok_len    = 0;
    tok_val    = '0;
    tok_bad    = 1'b0;
    magic_hits = 0;
    got_digit  = 1'b0;
  endfunction

  function automatic void reset_parser();
    hdr_phase  = PH_MAGIC;
    in_cmt     = 1'b0;
    restart_token();
    img_w      = '0;
    img_h      = '0;
    err_code   = ppmp6_pkg::ST_OK;
    bytes_left = '0;
    chan       = 0;
    red_hold   = '0;
    green_hold = '0;
  endfunction

  // only the first error sticks; the rest of the file is ignored
  function automatic void raise_error(logic [1:0] code);
    if (err_code == ppmp6_pkg::ST_OK)
      err_code = code;
    hdr_phase = PH_HALT;
  endfunction

  function automatic void take_char(logic [7:0] b);
    if (hdr_phase == PH_MAGIC) begin
      if (tok_len == 0 && b == ppmp6_pkg::CH_P)
        magic_hits = 1;
      else if (tok_len == 1 && b == ppmp6_pkg::CH_SIX && magic_hits == 1)
        magic_hits = 2;
      else
        tok_bad = 1'b1;
    end else if (b >= ppmp6_pkg::CH_ZERO && b <= ppmp6_pkg::CH_NINE) begin
      // value saturates just above 32 bits
      if (tok_val <= VALUE_MAX)
        tok_val = tok_val * 10 + 64'(b - ppmp6_pkg::CH_ZERO);
      if (tok_val > VALUE_MAX)
        tok_val = VALUE_MAX + 64'd1;
      got_digit = 1'b1;
    end else if (!(b == ppmp6_pkg::CH_PLUS && tok_len == 0)) begin
      tok_bad = 1'b1;
    end
    if (tok_len < ppmp6_pkg::MAX_TOKEN_LEN)
      tok_len++;
  endfunction

  function automatic bit number_ok();
    return tok_len < ppmp6_pkg::MAX_TOKEN_LEN && !tok_bad && got_digit &&
           tok_val <= VALUE_MAX;
  endfunction

  function automatic void end_token(token_end_e how);
    logic [63:0] pixels;
    if (hdr_phase == PH_MAGIC) begin
      if (tok_len >= ppmp6_pkg::MAX_TOKEN_LEN)
        raise_error(ppmp6_pkg::ST_CORRUPT);
      else if (tok_bad || tok_len != 2 || magic_hits != 2)
        raise_error(ppmp6_pkg::ST_UNSUPPORTED);
      else
        hdr_phase = PH_WIDTH;
    end else if (hdr_phase == PH_WIDTH || hdr_phase == PH_HEIGHT) begin
      if (!number_ok()) begin
        raise_error(ppmp6_pkg::ST_CORRUPT);
      end else if (hdr_phase == PH_WIDTH) begin
        img_w     = tok_val[31:0];
        hdr_phase = PH_HEIGHT;
      end else begin
        img_h     = tok_val[31:0];
        hdr_phase = PH_MAXVAL;
      end
    end else if (hdr_phase == PH_MAXVAL) begin
      if (!number_ok() || img_w == 0 || img_h == 0) begin
        raise_error(ppmp6_pkg::ST_CORRUPT);
      end else if (tok_val != 255) begin
        raise_error(ppmp6_pkg::ST_UNSUPPORTED);
      end else if (how != END_WS) begin
        raise_error(ppmp6_pkg::ST_CORRUPT);
      end else begin
        pixels = 64'(img_w) * 64'(img_h);
        if (pixels > MAX_PIXELS) begin
          raise_error(ppmp6_pkg::ST_CORRUPT);
        end else begin
          bytes_left = pixels * 3;
          chan       = 0;
          hdr_phase  = PH_RASTER;
        end
      end
    end
    restart_token();
    if (how == END_HASH && hdr_phase <= PH_MAXVAL)
      in_cmt = 1'b1;
  endfunction

  // advance the parser copy by one accepted byte, queue the beats it causes
  function automatic void parse_ppm_byte(logic [7:0] b, logic eof);
    ppmp6_pkg::out_beat_t beat;
    if (hdr_phase <= PH_MAXVAL) begin
      if (in_cmt) begin
        if (b == ppmp6_pkg::CH_LF || b == ppmp6_pkg::CH_CR)
          in_cmt = 1'b0;
      end else if (tok_len == 0) begin
        if (b == ppmp6_pkg::CH_HASH)
          in_cmt = 1'b1;
        else if (!is_space(b))
          take_char(b);
      end else if (is_space(b)) begin
        end_token(END_WS);
      end else if (b == ppmp6_pkg::CH_HASH) begin
        end_token(END_HASH);
      end else begin
        take_char(b);
      end
    end else if (hdr_phase == PH_RASTER) begin
      if (chan == 0) begin
        red_hold = b;
        chan     = 1;
      end else if (chan == 1) begin
        green_hold = b;
        chan       = 2;
      end else begin
        beat       = '0;
        beat.red   = red_hold;
        beat.green = green_hold;
        beat.blue  = b;
        ppm_beats_due.push_back(beat);
        chan = 0;
      end
      bytes_left--;
      if (bytes_left == 0)
        hdr_phase = PH_TRAIL;
    end else if (hdr_phase == PH_TRAIL) begin
      if (!is_space(b))
        raise_error(ppmp6_pkg::ST_CORRUPT);
    end

    if (eof) begin
      if (hdr_phase <= PH_MAXVAL && !in_cmt && tok_len != 0)
        end_token(END_EOF);
      if (hdr_phase <= PH_RASTER)
        raise_error(ppmp6_pkg::ST_CORRUPT);
      beat              = '0;
      beat.result_kind  = 1'b1;
      beat.parse_status = err_code;
      beat.final_item   = 1'b1;
      if (err_code == ppmp6_pkg::ST_OK) begin
        beat.image_width  = img_w;
        beat.image_height = img_h;
      end
      ppm_beats_due.push_back(beat);
      reset_parser();
    end
  endfunction

  // ---------------------------------------------------------------- file building

  function automatic void put_byte(logic [7:0] b);
    file_buf.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++)
      file_buf.push_back(s[i]);
  endfunction

  function automatic void put_run(logic [7:0] b, int n);
    repeat (n) file_buf.push_back(b);
  endfunction

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 5))
      0:       return ppmp6_pkg::CH_SPACE;
      1:       return ppmp6_pkg::CH_TAB;
      2:       return ppmp6_pkg::CH_LF;
      3:       return ppmp6_pkg::CH_CR;
      4:       return ppmp6_pkg::CH_FF;
      default: return ppmp6_pkg::CH_VT;
    endcase
  endfunction

  // one to three pieces of whitespace or comment
  function automatic void put_sep();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) != 0) begin
        put_byte(ws_byte());
      end else begin
        put_byte(ppmp6_pkg::CH_HASH);
        repeat ($urandom_range(0, 5)) begin
          c = 8'($urandom_range(0, 255));
          put_byte((c == ppmp6_pkg::CH_LF || c == ppmp6_pkg::CH_CR) ?
                   ppmp6_pkg::CH_SPACE : c);
        end
        put_byte($urandom_range(0, 1) ? ppmp6_pkg::CH_LF : ppmp6_pkg::CH_CR);
      end
    end
  endfunction

  // decimal token, sometimes with a plus sign or leading zeros
  function automatic void put_number(logic [31:0] v);
    if ($urandom_range(0, 4) == 0)
      put_byte(ppmp6_pkg::CH_PLUS);
    if ($urandom_range(0, 3) == 0)
      put_run(ppmp6_pkg::CH_ZERO, $urandom_range(1, 2));
    put_text($sformatf("%0d", v));
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // ---------------------------------------------------------------- byte side

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int                  gap;
    ppmp6_pkg::in_beat_t beat;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.data_byte   = b;
    beat.end_of_file = eof;
    byte_valid <= 1'b1;
    byte_data  <= beat;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    // beat taken at this edge
    parse_ppm_byte(b, eof);
  endtask

  // send the file under construction, eof on its last byte
  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++)
      send_byte(file_buf[i], i == file_buf.size() - 1);
    file_buf.delete();
  endtask

  // ---------------------------------------------------------------- result side

  // stall pattern: stretches of ready, then random stalls; none starts while calm
  always @(posedge clk) begin : ready_pattern
    int stall;
    if (hold_cycles != 0) begin
      hold_cycles--;
    end else if (calm || !result_ready) begin
      result_ready <= 1'b1;
      hold_cycles = $urandom_range(0, 15);
    end else begin
      stall = idle_len();
      if (stall != 0) begin
        result_ready <= 1'b0;
        hold_cycles = stall - 1;
      end
    end
  end

  function automatic string beat_text(ppmp6_pkg::out_beat_t b);
    return $sformatf("kind=%0d rgb=%02h_%02h_%02h w=%0d h=%0d st=%0d fin=%0d",
                     b.result_kind, b.red, b.green, b.blue, b.image_width,
                     b.image_height, b.parse_status, b.final_item);
  endfunction

  // every result beat against the oldest one due
  always @(posedge clk) begin : check_results
    ppmp6_pkg::out_beat_t want;
    ppmp6_pkg::out_beat_t got;
    if (!rst && result_valid && result_ready) begin
      got = result_data;
      if (ppm_beats_due.size() == 0) begin
        if (bad_beats < 10)
          $display("unexpected result beat: %s", beat_text(got));
        bad_beats++;
      end else begin
        want = ppm_beats_due.pop_front();
        if (got.result_kind !== want.result_kind || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.image_width !== want.image_width ||
            got.image_height !== want.image_height ||
            got.parse_status !== want.parse_status ||
            got.final_item !== want.final_item) begin
          if (bad_beats < 10) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected %s", beat_text(want));
            $display("  actual   %s", beat_text(got));
          end
          bad_beats++;
        end
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ppm_p6_stream_parser_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // well-formed files: extreme pixel values, every whitespace kind, comments,
  // plus signs, a token of one character less than the bound, trailing space
  task automatic test_good_images();
    // eof on the last raster byte gives a pixel and the status together
    put_text("P6\n1 1\n255\n");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    send_file();
    // '#' right after a token opens a comment
    put_text("P6#c\r+2\t");
    put_byte(ppmp6_pkg::CH_VT);
    put_text("1 #x\n255");
    put_byte(ppmp6_pkg::CH_FF);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(ppmp6_pkg::CH_LF);
    put_byte(ppmp6_pkg::CH_SPACE);
    put_byte(ppmp6_pkg::CH_HASH);
    put_byte(8'h7F);
    put_text(" \n");
    send_file();
    // longest legal token, and a raster that starts with whitespace
    put_text("P6 +");
    put_run(ppmp6_pkg::CH_ZERO, 29);
    put_text("1 1 0255\r\n");
    put_byte(8'h55);
    put_byte(8'hAA);
    send_file();
  endtask

  task automatic test_bad_magic();
    put_text("P5 1 1 255\n");
    send_file();
    put_text("p6\n");
    send_file();
    // magic token at the length bound
    put_byte(ppmp6_pkg::CH_P);
    put_run(ppmp6_pkg::CH_SIX, 31);
    put_byte(ppmp6_pkg::CH_LF);
    send_file();
    // lone P cut by end of file
    put_byte(ppmp6_pkg::CH_P);
    send_file();
  endtask

  task automatic test_bad_numbers();
    put_text("P6 -1 ");
    send_file();
    put_text("P6 1+2 ");
    send_file();
    put_text("P6 + ");
    send_file();
    put_text("P6 1a ");
    send_file();
    put_text("P6 1 4294967296 ");
    send_file();
    // number token at the length bound
    put_text("P6 ");
    put_run(ppmp6_pkg::CH_ZERO, 31);
    put_text("1 ");
    send_file();
  endtask

  task automatic test_zero_size();
    put_text("P6 0 1 255\n");
    send_file();
    // zero height wins over a bad maxval
    put_text("P6 1 0 254\n");
    send_file();
  endtask

  task automatic test_maxval();
    put_text("P6 1 1 254\n");
    send_file();
    // maxval ended by a comment
    put_text("P6 1 1 255#\n");
    send_file();
    // maxval ended by end of file
    put_text("P6 1 1 255");
    send_file();
  endtask

  task automatic test_size_overflow();
    put_text("P6 4294967295 4294967295 255\n");
    send_file();
    // legal size, raster cut short
    put_text("P6 4294967295 1 255\nabc");
    send_file();
  endtask

  task automatic test_early_end();
    put_text("P6 1");
    send_file();
    put_text("P6 #abc");
    send_file();
    // one pixel out, then the file stops mid-raster
    put_text("P6 2 1 255\nxyzw");
    send_file();
  endtask

  task automatic test_trailing_data();
    put_text("P6 1 1 255\nrgb x");
    send_file();
  endtask

  // after the first error nothing else counts, not even a later raster
  task automatic test_first_error();
    put_text("P6 x 1 254\nrgbrgb");
    send_file();
    put_text("P6 0 1 255\nrgb");
    send_file();
  endtask

  // mostly well-formed small images with random content; some carry a bad
  // field, some are mutated or cut, a few are pure noise
  task automatic test_random_files();
    int made;
    int shape;
    int w;
    int h;
    made = 0;
    while (made < RANDOM_BYTES) begin
      calm  = ($urandom_range(0, 5) == 0);
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        w = (shape < 11) ? 0 : $urandom_range(1, 3);
        h = (shape >= 11 && shape < 13) ? 0 : $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
          put_sep();
        put_text((shape >= 13 && shape < 15) ? "P3" : "P6");
        put_sep();
        put_number(w);
        put_sep();
        put_number(h);
        put_sep();
        put_number((shape >= 15 && shape < 18) ? $urandom_range(0, 300) : 255);
        // exactly one whitespace byte, sometimes a full separator
        if (shape >= 18 && shape < 21)
          put_sep();
        else
          put_byte(ws_byte());
        repeat (w * h * 3) put_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) put_byte(ws_byte());
        if (shape >= 82) begin
          case ($urandom_range(0, 2))
            0: file_buf[$urandom_range(0, file_buf.size() - 1)] =
                 8'($urandom_range(0, 255));
            1: begin
              h = $urandom_range(1, file_buf.size());
              while (file_buf.size() > h) void'(file_buf.pop_back());
            end
            default: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
      made += file_buf.size();
      send_file();
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_parser();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_good_images();
    test_bad_magic();
    test_bad_numbers();
    test_zero_size();
    test_maxval();
    test_size_overflow();
    test_early_end();
    test_trailing_data();
    test_first_error();
    test_random_files();

    byte_valid <= 1'b0;
    // drain, then give any stray beat time to show
    while (ppm_beats_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (bad_beats == 0 && ppm_beats_due.size() == 0)
      $display("[ppm_p6_stream_parser_top] OK");
    else
      $display("[ppm_p6_stream_parser_top] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/ppmp6_pkg.sv
src/ppmp6_front.sv
src/ppmp6_queue.sv
src/ppmp6_back.sv
src/ppm_p6_stream_parser_top.sv
verif/tb_top.sv
